>>> rtl/core/b64e_pkg.sv
// Shared types, constants and the alphabet function for the Base64 stream encoder.
// No dependencies; every other file of the encoder imports this package.
package b64e_pkg;

  // Character code and the per-item job carried from the front end to the back end.
  typedef logic [6:0] char_t;
  typedef logic [1:0] mode_t;

  localparam int MAX_CHARS = 6;
  localparam int CNT_W     = 3;

  typedef struct packed {
    logic [MAX_CHARS-1:0][6:0] chars;
    logic [CNT_W-1:0]          cnt;
  } job_t;

  // Mode register codes; the unused code behaves as standard.
  localparam mode_t MODE_STD  = 2'd0;
  localparam mode_t MODE_MIME = 2'd1;
  localparam mode_t MODE_URL  = 2'd2;

  // Group position codes.
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  localparam char_t CHAR_PAD = 7'h3D;
  localparam char_t CHAR_CR  = 7'h0D;
  localparam char_t CHAR_LF  = 7'h0A;

  localparam int LINE_CHARS_DEF  = 76;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Map a six-bit value onto the standard or URL-safe alphabet.
  function automatic char_t sextet_char(input logic [5:0] v, input logic url);
    char_t c;
    c = '0;
    if (v < 6'd26) begin
      c = 7'({1'b0, v}) + 7'd65;
    end else if (v < 6'd52) begin
      c = 7'({1'b0, v}) + 7'd71;
    end else if (v < 6'd62) begin
      c = 7'({1'b0, v}) - 7'd4;
    end else if (v == 6'd62) begin
      c = url ? 7'h2D : 7'h2B;
    end else begin
      c = url ? 7'h5F : 7'h2F;
    end
    return c;
  endfunction

endpackage

>>> rtl/core/b64e_front.sv
// Front end of the Base64 stream encoder: mode register, group state and job building.
// Depends on b64e_pkg.
module b64e_front #(
  parameter int LINE_CHARS = b64e_pkg::LINE_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  b64e_pkg::mode_t cfg_mode,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_final_byte,
  input  logic            q_full,
  output logic            q_push,
  output b64e_pkg::job_t  q_job
);
  import b64e_pkg::*;

  mode_t      mode_r;
  logic [1:0] pos_r, pos_nxt;
  logic [3:0] carry_r, carry_nxt;
  logic [6:0] line_r, line_nxt;
  logic       accept;
  logic       url;
  logic       padded;
  logic [2:0] idx;

  // Configuration writes are always taken; the user must write only while the block is idle, which it does not enforce.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_STD;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_mode;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = accept;
  assign url      = (mode_r == MODE_URL);
  assign padded   = (mode_r != MODE_URL);

  // Build the character list for this item and the next group state.
  always_comb begin
    q_job     = '0;
    idx       = '0;
    pos_nxt   = pos_r;
    carry_nxt = carry_r;
    line_nxt  = line_r;
    unique case (pos_r)
      POS_SECOND: begin
        q_job.chars[idx] = sextet_char({carry_r[1:0], in_data_byte[7:4]}, url);
        idx = idx + 3'd1;
        carry_nxt = in_data_byte[3:0];
        pos_nxt   = POS_THIRD;
        if (in_final_byte) begin
          q_job.chars[idx] = sextet_char({in_data_byte[3:0], 2'b00}, url);
          idx = idx + 3'd1;
          if (padded) begin
            q_job.chars[idx] = CHAR_PAD;
            idx = idx + 3'd1;
          end
        end
      end
      POS_THIRD: begin
        q_job.chars[idx] = sextet_char({carry_r, in_data_byte[7:6]}, url);
        idx = idx + 3'd1;
        q_job.chars[idx] = sextet_char(in_data_byte[5:0], url);
        idx = idx + 3'd1;
        carry_nxt = '0;
        pos_nxt   = POS_FIRST;
      end
      default: begin
        // A group begins here; MIME breaks the line first when it is full.
        if (mode_r == MODE_MIME) begin
          if (line_r >= 7'(LINE_CHARS)) begin
            q_job.chars[idx] = CHAR_CR;
            idx = idx + 3'd1;
            q_job.chars[idx] = CHAR_LF;
            idx = idx + 3'd1;
            line_nxt = 7'd4;
          end else begin
            line_nxt = line_r + 7'd4;
          end
        end
        q_job.chars[idx] = sextet_char(in_data_byte[7:2], url);
        idx = idx + 3'd1;
        carry_nxt = {2'b00, in_data_byte[1:0]};
        pos_nxt   = POS_SECOND;
        if (in_final_byte) begin
          q_job.chars[idx] = sextet_char({in_data_byte[1:0], 4'b0000}, url);
          idx = idx + 3'd1;
          if (padded) begin
            q_job.chars[idx] = CHAR_PAD;
            idx = idx + 3'd1;
            q_job.chars[idx] = CHAR_PAD;
            idx = idx + 3'd1;
          end
        end
      end
    endcase
    q_job.cnt = idx;
    // The last byte of a message returns the group state to its reset values.
    if (in_final_byte) begin
      pos_nxt   = POS_FIRST;
      carry_nxt = '0;
      line_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_FIRST;
      carry_r <= '0;
      line_r  <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      carry_r <= carry_nxt;
      line_r  <= line_nxt;
    end
  end

  // Every job carries at least one character.
  a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_job.cnt != 3'd0))
    else $error("front end produced an empty job");

  // The group position never reaches the unused code.
  a_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != 2'd3)
    else $error("group position left its range");

  // After a final byte the state is back at its reset values.
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_final_byte |=> (pos_r == POS_FIRST) && (carry_r == 4'd0) && (line_r == 7'd0))
    else $error("state not cleared after final byte");

endmodule

>>> rtl/core/b64e_queue.sv
// Short job queue between the front and back ends of the Base64 stream encoder.
// Depends on b64e_pkg.
module b64e_queue #(
  parameter int DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output b64e_pkg::job_t head_job
);
  import b64e_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_job  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Entry storage; no reset needed on the payload.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers wrap at the depth, which need not be a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

>>> rtl/core/b64e_back.sv
// Back end of the Base64 stream encoder: sends the queued characters one per cycle unless out_stall holds them.
// Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  b64e_pkg::job_t q_head,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [6:0]     out_char,
  output logic           out_run_end
);
  import b64e_pkg::*;

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             valid_r, valid_nxt;
  char_t            char_r, char_nxt;
  logic             end_r, end_nxt;
  logic             load;
  logic             last_char;

  // The output register takes a new character when it is empty or being drained.
  assign load      = q_not_empty && (!valid_r || !out_stall);
  assign last_char = (idx_r == q_head.cnt - 3'd1);
  assign q_pop     = load && last_char;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    char_nxt  = char_r;
    end_nxt   = end_r;
    if (load) begin
      valid_nxt = 1'b1;
      char_nxt  = q_head.chars[idx_r];
      end_nxt   = last_char;
      idx_nxt   = last_char ? '0 : idx_r + 3'd1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk) begin
    char_r <= char_nxt;
    end_r  <= end_nxt;
  end

  assign out_valid   = valid_r;
  assign out_char    = char_r;
  assign out_run_end = end_r;

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    q_not_empty |-> (idx_r < q_head.cnt))
    else $error("character index beyond job length");

  a_idx_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !q_not_empty |-> (idx_r == '0))
    else $error("character index not reset between jobs");

  a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_valid && out_run_end)
    else $error("job finished without a run end mark");

endmodule

>>> rtl/core/base64_stream_encoder.sv
// Base64 stream encoder, one byte an item in, one character a result out.
// Each item is registered in the queue, and its first character then in the output register.
// Throughput: one character a cycle while out_stall is low and jobs are queued; an item
// yields 1 to 6 characters (4 for every 3 items in a long message, more with padding and
// line breaks); the single output register sets this rate.
// Reset (rst_n, synchronous, active low) clears the mode to standard and the group state.
module base64_stream_encoder #(
  parameter int LINE_CHARS  = b64e_pkg::LINE_CHARS_DEF,
  parameter int QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  b64e_pkg::mode_t cfg_mode,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_final_byte,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [6:0]      out_char,
  output logic            out_run_end
);
  import b64e_pkg::*;

  job_t push_job;
  job_t head_job;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;

  // Front end: takes items and turns each into a job of characters.
  b64e_front #(
    .LINE_CHARS (LINE_CHARS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_mode      (cfg_mode),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_job         (push_job)
  );

  // Queue between the two sides.
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  // Back end: sends the characters of each job in order.
  b64e_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (head_job),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .out_run_end (out_run_end)
  );

endmodule
